// File: sv/mwsf_pkg.sv
// ============================================================================
// mwsf_pkg: shared types and constants
// Fixed field widths and the step control word passed from the top level
// to the window tracker.
// ============================================================================
package mwsf_pkg;

    localparam int CFG_W        = 9;
    localparam int BEST_START_W = 16;
    localparam int BEST_SUM_W   = 24;

    typedef struct packed {
        logic accept;
        logic last;
        logic clear;
    } step_ctrl_t;

endpackage

// File: sv/mwsf_cell.sv
// ============================================================================
// mwsf_cell: one stage of the sample delay chain
// Holds one sample. On each accepted word it takes the new sample if it is
// the injection stage for the current window length, else its neighbor's.
// ============================================================================
module mwsf_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int IDX_W       = 8,
    parameter int CELL_INDEX  = 0
) (
    input  logic                          aclk,
    input  logic                          shift_en,
    input  logic [IDX_W-1:0]              inject_pos,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic signed [SAMPLE_BITS-1:0] prev_in,
    output logic signed [SAMPLE_BITS-1:0] data_out
);

    logic signed [SAMPLE_BITS-1:0] data_reg;
    logic signed [SAMPLE_BITS-1:0] data_next;

    always_comb begin
        if (inject_pos == IDX_W'(CELL_INDEX)) begin
            data_next = sample_in;
        end else begin
            data_next = prev_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= data_next;
        end
    end

    assign data_out = data_reg;

endmodule

// File: sv/mwsf_track.sv
// ============================================================================
// mwsf_track: running window sum and best window tracker
// Keeps the item count, running sum, best sum and best start index, and
// forms the result fields for the current word.
// ============================================================================
module mwsf_track #(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_W       = 25,
    parameter int CNT_W       = 16,
    parameter int LEN_W       = 9,
    parameter int MAX_ITEMS   = 65536
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  mwsf_pkg::step_ctrl_t                  ctrl,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    input  logic signed [SAMPLE_BITS-1:0]         old_sample,
    input  logic [LEN_W-1:0]                      win_len,
    output logic [mwsf_pkg::BEST_START_W-1:0]     res_start,
    output logic signed [mwsf_pkg::BEST_SUM_W-1:0] res_sum,
    output logic                                  res_too_short
);

    localparam int CMP_W     = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
    localparam int IDX_EXT_W = (CNT_W > mwsf_pkg::BEST_START_W) ? CNT_W
                                                                : mwsf_pkg::BEST_START_W;
    localparam int SUM_EXT_W = (SUM_W > mwsf_pkg::BEST_SUM_W) ? SUM_W
                                                              : mwsf_pkg::BEST_SUM_W;

    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [SUM_W-1:0] best_reg, best_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;

    logic [CMP_W-1:0]            i_w, len_w;
    logic                        full, fill_done;
    logic signed [SUM_W-1:0]     x_ext, old_ext;
    logic [IDX_EXT_W-1:0]        idx_ext;
    logic signed [SUM_EXT_W-1:0] sum_ext;

    always_comb begin
        i_w       = CMP_W'(count_reg);
        len_w     = CMP_W'(win_len);
        full      = (i_w >= len_w);
        fill_done = ((i_w + CMP_W'(1)) == len_w);
        x_ext     = SUM_W'(sample);
        old_ext   = SUM_W'(old_sample);

        if (full) begin
            sum_next = sum_reg + x_ext - old_ext;
        end else begin
            sum_next = sum_reg + x_ext;
        end

        best_next = best_reg;
        idx_next  = idx_reg;
        if (!full) begin
            if (fill_done) begin
                best_next = sum_next;
                idx_next  = '0;
            end
        end else if (sum_next >= best_reg) begin
            best_next = sum_next;
            idx_next  = CNT_W'(i_w - len_w + CMP_W'(1));
        end

        if (count_reg < CNT_W'(MAX_ITEMS - 1)) begin
            count_next = count_reg + CNT_W'(1);
        end else begin
            count_next = count_reg;
        end
    end

    always_comb begin
        res_too_short = ((i_w + CMP_W'(1)) < len_w);
        idx_ext       = IDX_EXT_W'(idx_next);
        sum_ext       = SUM_EXT_W'(best_next);
        if (res_too_short) begin
            res_start = '0;
            res_sum   = '0;
        end else begin
            res_start = idx_ext[mwsf_pkg::BEST_START_W-1:0];
            res_sum   = sum_ext[mwsf_pkg::BEST_SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear || (ctrl.accept && ctrl.last)) begin
            count_reg <= '0;
            sum_reg   <= '0;
            best_reg  <= '0;
            idx_reg   <= '0;
        end else if (ctrl.accept) begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            best_reg  <= best_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// File: sv/max_window_sum_finder_unit.sv
// ============================================================================
// max_window_sum_finder_unit: maximum-sum fixed-length sliding window
// Output: the result word is registered when the marked last sample is
//   accepted.
// Throughput: one sample per cycle while no unaccepted result holds s_ready
//   low, set by the add, subtract and compare in the window tracker; the delay chain shifts every accepted word.
// Reset: synchronous, active low; clears the tracker and the output valid.
//   The delay chain needs no clearing pass.
// ============================================================================
module max_window_sum_finder_unit #(
    parameter int WINDOW_MAX  = 256,
    parameter int MAX_ITEMS   = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   cfg_wr_en,
    input  logic [mwsf_pkg::CFG_W-1:0]             cfg_wr_data,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [SAMPLE_BITS-1:0]          s_sample,
    input  logic                                   s_last_sample,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [mwsf_pkg::BEST_START_W-1:0]      m_best_start,
    output logic signed [mwsf_pkg::BEST_SUM_W-1:0] m_best_sum,
    output logic                                   m_too_short
);

    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_MAX) + 1;
    localparam int CNT_W  = $clog2(MAX_ITEMS);
    localparam int LEN_CW = (LEN_W > mwsf_pkg::CFG_W) ? LEN_W : mwsf_pkg::CFG_W;

    logic [LEN_W-1:0]  len_reg, len_next;
    logic [IDX_W-1:0]  inject_reg, inject_next;
    logic [LEN_CW-1:0] cfg_ext, eff_len;

    logic                                   accept;
    mwsf_pkg::step_ctrl_t                   ctrl;
    logic signed [SAMPLE_BITS-1:0]          chain_q [WINDOW_MAX];
    logic [mwsf_pkg::BEST_START_W-1:0]      res_start;
    logic signed [mwsf_pkg::BEST_SUM_W-1:0] res_sum;
    logic                                   res_too_short;

    logic                                   m_valid_reg;
    logic [mwsf_pkg::BEST_START_W-1:0]      start_reg;
    logic signed [mwsf_pkg::BEST_SUM_W-1:0] sum_reg;
    logic                                   short_reg;

    // clamp window length into 1..WINDOW_MAX
    always_comb begin
        cfg_ext = LEN_CW'(cfg_wr_data);
        if (cfg_ext == '0) begin
            eff_len = LEN_CW'(1);
        end else if (cfg_ext > LEN_CW'(WINDOW_MAX)) begin
            eff_len = LEN_CW'(WINDOW_MAX);
        end else begin
            eff_len = cfg_ext;
        end
        len_next    = LEN_W'(eff_len);
        inject_next = IDX_W'(LEN_CW'(WINDOW_MAX) - eff_len);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg    <= LEN_W'(1);
            inject_reg <= IDX_W'(WINDOW_MAX - 1);
        end else if (cfg_wr_en) begin
            len_reg    <= len_next;
            inject_reg <= inject_next;
        end
    end

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign ctrl    = {accept, s_last_sample, cfg_wr_en};

    genvar k;
    generate
        for (k = 0; k < WINDOW_MAX; k++) begin : g_cell
            if (k == 0) begin : g_head
                mwsf_cell #(
                    .SAMPLE_BITS (SAMPLE_BITS),
                    .IDX_W       (IDX_W),
                    .CELL_INDEX  (k)
                ) u_cell (
                    .aclk       (aclk),
                    .shift_en   (accept),
                    .inject_pos (inject_reg),
                    .sample_in  (s_sample),
                    .prev_in    (s_sample),
                    .data_out   (chain_q[k])
                );
            end else begin : g_body
                mwsf_cell #(
                    .SAMPLE_BITS (SAMPLE_BITS),
                    .IDX_W       (IDX_W),
                    .CELL_INDEX  (k)
                ) u_cell (
                    .aclk       (aclk),
                    .shift_en   (accept),
                    .inject_pos (inject_reg),
                    .sample_in  (s_sample),
                    .prev_in    (chain_q[k-1]),
                    .data_out   (chain_q[k])
                );
            end
        end
    endgenerate

    mwsf_track #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W),
        .CNT_W       (CNT_W),
        .LEN_W       (LEN_W),
        .MAX_ITEMS   (MAX_ITEMS)
    ) u_track (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .sample        (s_sample),
        .old_sample    (chain_q[WINDOW_MAX-1]),
        .win_len       (len_reg),
        .res_start     (res_start),
        .res_sum       (res_sum),
        .res_too_short (res_too_short)
    );

    // hold result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && s_last_sample) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_last_sample) begin
            start_reg <= res_start;
            sum_reg   <= res_sum;
            short_reg <= res_too_short;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_best_start = start_reg;
    assign m_best_sum   = sum_reg;
    assign m_too_short  = short_reg;

`ifndef NO_ASSERTIONS
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_sample) |=> m_valid)
        else $error("last sample accepted without a result");

    a_result_has_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_last_sample))
        else $error("result raised without a last sample");

    a_short_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_too_short) |-> (m_best_start == '0 && m_best_sum == '0))
        else $error("too_short result with nonzero fields");
`endif

endmodule
